>>> src/sbcc_pkg.sv
package sbcc_pkg;

   // Number of positions in each table.
   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   // Worst-case number of probes of the binary search over TABLE_ENTRIES keys.
   localparam int PROBES = $clog2(TABLE_ENTRIES + 1);
   // Clock edges from an accepted request to the edge that takes its result.
   localparam int RSP_LATENCY = PROBES + 3;

   localparam int CODE_W = 16;
   localparam int BYTE_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MAP_COUNT_W = 9;
   localparam logic [CODE_W-1:0] UNUSED_CODE = 16'hFFFF;
   localparam logic [CODE_W-1:0] REPLACEMENT_RESET = 16'hFFFD;

   typedef enum logic [1:0] {
      MODE_DECODE     = 2'd0,
      MODE_ENCODE     = 2'd1,
      MODE_LOAD_BYTES = 2'd2,
      MODE_LOAD_MAP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REPLACED = 2'd1,
      ST_STOP     = 2'd2,
      ST_ERROR    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_REPLACE = 2'd0,
      ACT_STOP    = 2'd1,
      ACT_ERROR   = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ERROR_ACTION = 2'd0,
      CSR_REPLACEMENT  = 2'd1,
      CSR_MAP_ENTRIES  = 2'd2
   } csr_index_type;

   typedef struct packed {
      mode_type           mode;
      logic [CODE_W-1:0]  code_value;
      logic [BYTE_W-1:0]  load_index;
      logic [BYTE_W-1:0]  load_byte;
      logic               first_in_block;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] result_value;
      status_type        status;
   } rsp_type;

   // One slot of the search pipeline.
   typedef struct packed {
      logic              valid;
      mode_type          mode;
      logic [CODE_W-1:0] code;
      logic [BYTE_W-1:0] load_index;
      logic [BYTE_W-1:0] load_byte;
      logic              first;
      logic [CODE_W-1:0] dec_word;
      logic [CNT_W-1:0]  lo;
      logic [CNT_W-1:0]  hi;
      logic [IDX_W-1:0]  mid;
      logic              active;
      logic              hit;
      logic [IDX_W-1:0]  pos;
   } stage_type;

   function automatic logic idx_in_range(input logic [BYTE_W-1:0] idx);
      return (32'(idx) < TABLE_ENTRIES);
   endfunction

endpackage

>>> src/single_byte_charset_converter_unit.sv
// Single-byte code page converter. A request is taken on every clock edge at which start is
// high; busy stays low, so requests may follow one another without a gap. Load requests fill
// the byte-to-wide table or one pair of the sorted wide-to-byte map and give no result. Decode
// and encode requests give one result each in request order, strobed on rsp_strobe for a single
// cycle. The pipeline depth is set by the binary search: each of its nine probes is a pipeline
// stage with its own copy of the key memory, which every map load writes as it passes that
// stage. The receiver cannot hold results off. Configuration registers may only be written while
// no request is in flight. Table entries that were never loaded read back as unknown values.
module single_byte_charset_converter_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  sbcc_pkg::req_type                         req_data,
   output logic                                      rsp_strobe,
   output sbcc_pkg::rsp_type                         rsp_data,
   input  logic                                      csr_we,
   input  logic [sbcc_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [sbcc_pkg::CSR_DATA_W-1:0]           csr_wdata
);
   import sbcc_pkg::*;

   logic [1:0]             error_action_ff;
   logic [CODE_W-1:0]      replacement_ff;
   logic [MAP_COUNT_W-1:0] map_entries_ff;

   logic                   in_valid_ff;
   req_type                in_req_ff;

   stage_type              src [PROBES+1];
   stage_type              stage_ff [PROBES];
   logic [CODE_W-1:0]      key_rd_ff [PROBES];

   logic [CODE_W-1:0]      b2w_mem [TABLE_ENTRIES];
   logic [CODE_W-1:0]      b2w_rd_ff;
   logic [BYTE_W-1:0]      map_bytes_mem [TABLE_ENTRIES];
   logic [BYTE_W-1:0]      mb_rd_ff;

   stage_type              fin_ff;
   logic [CNT_W-1:0]       first_hi;

   logic                   rsp_strobe_in;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_data_in;
   rsp_type                rsp_data_ff;
   status_type             fail_status;

   // One probe of the search: compare the key read for mid, then narrow the range.
   function automatic stage_type probe_step(input stage_type s, input logic [CODE_W-1:0] key);
      stage_type        r;
      logic [CNT_W-1:0] lo_n;
      logic [CNT_W-1:0] hi_n;
      logic [CNT_W:0]   sum;
      r = s;
      lo_n = s.lo;
      hi_n = s.hi;
      sum = '0;
      if (s.active) begin
         if (key == s.code) begin
            r.hit = 1'b1;
            r.pos = s.mid;
            r.active = 1'b0;
         end else begin
            if (key > s.code) begin
               hi_n = {1'b0, s.mid};
            end else begin
               lo_n = CNT_W'({1'b0, s.mid} + 1'b1);
            end
            sum = {1'b0, lo_n} + {1'b0, hi_n};
            r.lo = lo_n;
            r.hi = hi_n;
            r.active = (lo_n < hi_n);
            r.mid = sum[IDX_W:1];
         end
      end
      return r;
   endfunction

   assign busy = 1'b0;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_action_ff <= ACT_REPLACE;
         replacement_ff <= REPLACEMENT_RESET;
         map_entries_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ERROR_ACTION: error_action_ff <= csr_wdata[1:0];
            CSR_REPLACEMENT:  replacement_ff <= csr_wdata;
            CSR_MAP_ENTRIES:  map_entries_ff <= csr_wdata[MAP_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_req_ff <= req_data;
   end

   assign first_hi = (32'(map_entries_ff) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                          : CNT_W'(map_entries_ff);

   always_comb begin
      src[0].valid = in_valid_ff;
      src[0].mode = in_req_ff.mode;
      src[0].code = in_req_ff.code_value;
      src[0].load_index = in_req_ff.load_index;
      src[0].load_byte = in_req_ff.load_byte;
      src[0].first = in_req_ff.first_in_block;
      src[0].dec_word = '0;
      src[0].lo = '0;
      src[0].hi = first_hi;
      src[0].mid = first_hi[CNT_W-1:1];
      src[0].active = in_valid_ff && (in_req_ff.mode == MODE_ENCODE) && (first_hi != '0);
      src[0].hit = 1'b0;
      src[0].pos = '0;
   end

   // Byte-to-wide table: loads and decode reads both happen as the request enters the pipeline.
   always_ff @(posedge clock) begin
      if (src[0].valid && src[0].mode == MODE_LOAD_BYTES && idx_in_range(src[0].load_index)) begin
         b2w_mem[src[0].load_index[IDX_W-1:0]] <= src[0].code;
      end
      b2w_rd_ff <= b2w_mem[src[0].code[IDX_W-1:0]];
   end

   for (genvar k = 0; k < PROBES; k++) begin : g_probe
      logic [CODE_W-1:0] key_mem [TABLE_ENTRIES];

      // Each probe stage owns a copy of the keys; a map load writes it on its way past, so
      // every search sees exactly the loads that came before it.
      always_ff @(posedge clock) begin
         if (src[k].valid && src[k].mode == MODE_LOAD_MAP && idx_in_range(src[k].load_index))
         begin
            key_mem[src[k].load_index[IDX_W-1:0]] <= src[k].code;
         end
         key_rd_ff[k] <= key_mem[src[k].mid];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k] <= src[k];
         end
      end

      if (k == 0) begin : g_first
         always_comb begin
            src[k+1] = probe_step(stage_ff[k], key_rd_ff[k]);
            src[k+1].dec_word = idx_in_range(stage_ff[k].code[BYTE_W-1:0]) ? b2w_rd_ff
                                                                             : UNUSED_CODE;
         end
      end else begin : g_next
         assign src[k+1] = probe_step(stage_ff[k], key_rd_ff[k]);
      end
   end

   // Byte side of the map, read at the position the search ended on.
   always_ff @(posedge clock) begin
      if (src[PROBES].valid && src[PROBES].mode == MODE_LOAD_MAP
          && idx_in_range(src[PROBES].load_index)) begin
         map_bytes_mem[src[PROBES].load_index[IDX_W-1:0]] <= src[PROBES].load_byte;
      end
      mb_rd_ff <= map_bytes_mem[src[PROBES].pos];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.valid <= 1'b0;
      end else begin
         fin_ff <= src[PROBES];
      end
   end

   always_comb begin
      fail_status = (error_action_ff == ACT_STOP && !fin_ff.first) ? ST_STOP : ST_ERROR;
      rsp_data_in.result_value = '0;
      rsp_data_in.status = ST_OK;
      rsp_strobe_in = fin_ff.valid
                      && (fin_ff.mode == MODE_DECODE || fin_ff.mode == MODE_ENCODE);
      if (fin_ff.mode == MODE_DECODE) begin
         if (fin_ff.dec_word != UNUSED_CODE) begin
            rsp_data_in.result_value = fin_ff.dec_word;
         end else if (error_action_ff == ACT_REPLACE) begin
            rsp_data_in.result_value = replacement_ff;
            rsp_data_in.status = ST_REPLACED;
         end else begin
            rsp_data_in.status = fail_status;
         end
      end else begin
         if (fin_ff.hit) begin
            rsp_data_in.result_value = {{(CODE_W-BYTE_W){1'b0}}, mb_rd_ff};
         end else begin
            rsp_data_in.status = fail_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> src/sbcc_checker.sv
module sbcc_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic                                      busy,
   input  sbcc_pkg::req_type                         req_data,
   input  logic                                      rsp_strobe,
   input  sbcc_pkg::rsp_type                         rsp_data,
   input  logic                                      csr_we,
   input  logic [sbcc_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [sbcc_pkg::CSR_DATA_W-1:0]           csr_wdata
);
   import sbcc_pkg::*;

   logic [RSP_LATENCY-1:0] expect_sr_ff;
   logic [1:0]             action_ff;
   logic [CODE_W-1:0]      repl_ff;
   logic                   conv_accept;

   assign conv_accept = start && !busy
                        && (req_data.mode == MODE_DECODE || req_data.mode == MODE_ENCODE);

   // Marks requests that must come back as a result, shifted along with the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_sr_ff <= '0;
         action_ff <= ACT_REPLACE;
         repl_ff <= REPLACEMENT_RESET;
      end else begin
         expect_sr_ff <= {expect_sr_ff[RSP_LATENCY-2:0], conv_accept};
         if (csr_we && csr_index == CSR_ERROR_ACTION) begin
            action_ff <= csr_wdata[1:0];
         end
         if (csr_we && csr_index == CSR_REPLACEMENT) begin
            repl_ff <= csr_wdata;
         end
      end
   end

   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == expect_sr_ff[RSP_LATENCY-1])
      else $error("result strobe does not match an earlier decode or encode request");

   a_failed_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == ST_STOP || rsp_data.status == ST_ERROR)
      |-> rsp_data.result_value == '0)
      else $error("failed conversion carries a non-zero value");

   a_replaced_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_REPLACED
      |-> $past(action_ff) == ACT_REPLACE && rsp_data.result_value == $past(repl_ff))
      else $error("replacement given outside replace mode or with the wrong character");

   a_stop_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_STOP |-> $past(action_ff) == ACT_STOP)
      else $error("stop status given while the error action is not stop");

endmodule

bind single_byte_charset_converter_unit sbcc_checker u_sbcc_checker (.*);

>>> verif/tb_single_byte_charset_converter_unit.sv
`timescale 1ns / 1ps

module tb_single_byte_charset_converter_unit;
   import sbcc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 345;

   typedef struct {
      bit                     is_csr;
      csr_index_type          csr_sel;
      logic [CSR_DATA_W-1:0]  csr_value;
      req_type                req;
      bit                     is_known;
      rsp_type                known;
   } vector_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the configuration and the three tables.
   logic [1:0]             cfg_action = ACT_REPLACE;
   logic [CODE_W-1:0]      cfg_replacement = REPLACEMENT_RESET;
   logic [MAP_COUNT_W-1:0] cfg_map_entries = '0;
   logic [CODE_W-1:0]      byte_table [TABLE_ENTRIES];
   logic [CODE_W-1:0]      map_keys [TABLE_ENTRIES];
   logic [BYTE_W-1:0]      map_bytes [TABLE_ENTRIES];

   rsp_type                pending_conversions [$];
   bit                     known_pending = 1'b0;
   rsp_type                known_rsp = '0;
   int                     mismatches = 0;
   int                     stall_cycles = 0;

   // Stimulus bookkeeping: which positions have been loaded, so that no
   // unloaded entry is ever read back.
   bit                     byte_loaded [TABLE_ENTRIES];
   bit                     map_loaded [TABLE_ENTRIES];
   logic [CODE_W-1:0]      planned_keys [TABLE_ENTRIES];
   int                     map_size_now = 0;
   int                     items_sent = 0;
   int                     idle_pct = 19;
   vector_row_type         rows [$];

   single_byte_charset_converter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic status_type miss_status(input logic first);
      return (cfg_action == ACT_STOP && !first) ? ST_STOP : ST_ERROR;
   endfunction

   function automatic bit convert_request(input req_type r, output rsp_type o);
      logic [CODE_W-1:0] word;
      int                lo;
      int                hi;
      int                mid;
      bit                found;
      o.result_value = '0;
      o.status = ST_OK;
      case (r.mode)
         MODE_LOAD_BYTES: begin
            byte_table[r.load_index] = r.code_value;
            return 1'b0;
         end
         MODE_LOAD_MAP: begin
            map_keys[r.load_index] = r.code_value;
            map_bytes[r.load_index] = r.load_byte;
            return 1'b0;
         end
         MODE_DECODE: begin
            word = byte_table[r.code_value[BYTE_W-1:0]];
            if (word != UNUSED_CODE) begin
               o.result_value = word;
            end else if (cfg_action == ACT_REPLACE) begin
               o.result_value = cfg_replacement;
               o.status = ST_REPLACED;
            end else begin
               o.status = miss_status(r.first_in_block);
            end
         end
         default: begin
            lo = 0;
            hi = (cfg_map_entries > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg_map_entries);
            found = 1'b0;
            mid = 0;
            while (lo < hi && !found) begin
               mid = (lo + hi) / 2;
               if (map_keys[mid] == r.code_value) found = 1'b1;
               else if (map_keys[mid] > r.code_value) hi = mid;
               else lo = mid + 1;
            end
            if (found) o.result_value = {8'h00, map_bytes[mid]};
            else o.status = miss_status(r.first_in_block);
         end
      endcase
      return 1'b1;
   endfunction

   task automatic flag_result(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : monitor
      rsp_type fresh;
      rsp_type want;
      bit      gives;
      bit      active;
      if (reset == 1'b0) begin
         active = 1'b0;
         if (csr_we === 1'b1) begin
            active = 1'b1;
            case (csr_index)
               CSR_ERROR_ACTION: cfg_action = csr_wdata[1:0];
               CSR_REPLACEMENT:  cfg_replacement = csr_wdata;
               CSR_MAP_ENTRIES:  cfg_map_entries = csr_wdata[MAP_COUNT_W-1:0];
               default: ;
            endcase
         end
         if (start === 1'b1 && busy === 1'b0) begin
            active = 1'b1;
            gives = convert_request(req_data, fresh);
            if (gives) pending_conversions.push_back(known_pending ? known_rsp : fresh);
         end
         if (rsp_strobe === 1'b1) begin
            active = 1'b1;
            if (pending_conversions.size() == 0) begin
               flag_result($sformatf("unexpected result: value %h status %0d",
                                     rsp_data.result_value, rsp_data.status));
            end else begin
               want = pending_conversions.pop_front();
               if (rsp_data.result_value !== want.result_value ||
                   rsp_data.status !== want.status)
                  flag_result($sformatf("result mismatch: value %h (want %h), status %0d (want %0d)",
                                        rsp_data.result_value, want.result_value,
                                        rsp_data.status, want.status));
            end
         end
         stall_cycles = active ? 0 : stall_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic req_type req_row(input mode_type mode, input logic [CODE_W-1:0] code,
                                       input logic [BYTE_W-1:0] idx,
                                       input logic [BYTE_W-1:0] lbyte, input logic first);
      req_type r;
      r.mode = mode;
      r.code_value = code;
      r.load_index = idx;
      r.load_byte = lbyte;
      r.first_in_block = first;
      return r;
   endfunction

   function automatic vector_row_type plain_row(input req_type r);
      vector_row_type v;
      v.is_csr = 1'b0;
      v.csr_sel = CSR_ERROR_ACTION;
      v.csr_value = '0;
      v.req = r;
      v.is_known = 1'b0;
      v.known = '0;
      return v;
   endfunction

   function automatic vector_row_type known_result(input req_type r,
                                                   input logic [CODE_W-1:0] value,
                                                   input status_type status);
      vector_row_type v;
      v = plain_row(r);
      v.is_known = 1'b1;
      v.known.result_value = value;
      v.known.status = status;
      return v;
   endfunction

   function automatic vector_row_type csr_row(input csr_index_type sel,
                                              input logic [CSR_DATA_W-1:0] value);
      vector_row_type v;
      v = plain_row('0);
      v.is_csr = 1'b1;
      v.csr_sel = sel;
      v.csr_value = value;
      return v;
   endfunction

   task automatic send_request(input req_type r, input bit is_known, input rsp_type known);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      known_pending <= is_known;
      known_rsp <= known;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      items_sent++;
      if (r.mode == MODE_LOAD_BYTES) begin
         byte_loaded[r.load_index] = 1'b1;
      end else if (r.mode == MODE_LOAD_MAP) begin
         map_loaded[r.load_index] = 1'b1;
         planned_keys[r.load_index] = r.code_value;
      end
   endtask

   // Holds requests back until every expected result is in, then lets any
   // load still in the pipeline run out.
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (pending_conversions.size() != 0) @(negedge clock);
      repeat (RSP_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_MAP_ENTRIES) map_size_now = int'(value);
   endtask

   function automatic req_type random_request();
      req_type           r;
      int                pick;
      int                b;
      int                p;
      int                span;
      logic [CODE_W-1:0] key;
      r.code_value = CODE_W'($urandom);
      r.load_index = BYTE_W'($urandom);
      r.load_byte = BYTE_W'($urandom);
      r.first_in_block = ($urandom_range(3) == 0);
      pick = $urandom_range(99);
      if (pick < 35) begin
         r.mode = MODE_DECODE;
         do b = $urandom_range(TABLE_ENTRIES - 1); while (!byte_loaded[b]);
         r.code_value = {($urandom_range(1) != 0) ? BYTE_W'($urandom) : 8'h00, BYTE_W'(b)};
      end else if (pick < 70) begin
         r.mode = MODE_ENCODE;
         span = (map_size_now > TABLE_ENTRIES) ? TABLE_ENTRIES : map_size_now;
         if (span > 0 && $urandom_range(2) != 0) begin
            p = $urandom_range(span - 1);
            key = planned_keys[p];
            // Near misses sit right beside a stored key.
            if ($urandom_range(3) == 0) key = ($urandom_range(1) != 0) ? key + 1'b1 : key - 1'b1;
            r.code_value = key;
         end
      end else if (pick < 85) begin
         r.mode = MODE_LOAD_BYTES;
         if ($urandom_range(3) == 0) r.code_value = UNUSED_CODE;
      end else begin
         r.mode = MODE_LOAD_MAP;
         p = int'(r.load_index);
         // Mostly a new byte under the same key, which keeps the map sorted.
         if (map_loaded[p] && $urandom_range(4) != 0) r.code_value = planned_keys[p];
      end
      return r;
   endfunction

   task automatic run_episode(input bit want_full);
      int                n;
      int                gap;
      int                prefix;
      int                m;
      int                count;
      logic [CODE_W-1:0] key;
      logic [CSR_DATA_W-1:0] repl;
      drain_block();
      write_register(CSR_ERROR_ACTION, CSR_DATA_W'($urandom_range(3)));
      case ($urandom_range(3))
         0: repl = '0;
         1: repl = '1;
         default: repl = CSR_DATA_W'($urandom);
      endcase
      write_register(CSR_REPLACEMENT, repl);
      if (want_full || $urandom_range(2) == 0) begin
         n = want_full ? TABLE_ENTRIES : $urandom_range(1, 24);
         gap = 65535 / (n + 1);
         key = ($urandom_range(3) == 0) ? '0 : CODE_W'($urandom_range(gap));
         for (int i = 0; i < n; i++) begin
            if (i == n - 1 && $urandom_range(3) == 0) key = UNUSED_CODE;
            send_request(req_row(MODE_LOAD_MAP, key, BYTE_W'(i), BYTE_W'($urandom), 1'b0),
                         1'b0, '0);
            // Now and then the next key repeats this one.
            key = key + CODE_W'(($urandom_range(15) == 0) ? 0 : $urandom_range(1, gap));
         end
         drain_block();
         write_register(CSR_MAP_ENTRIES, CSR_DATA_W'(n));
      end else begin
         prefix = 0;
         while (prefix < TABLE_ENTRIES && map_loaded[prefix]) prefix++;
         m = ($urandom_range(3) == 0) ? map_size_now : $urandom_range(prefix);
         if (prefix == TABLE_ENTRIES && $urandom_range(3) == 0)
            m = $urandom_range(TABLE_ENTRIES + 1, 511);
         write_register(CSR_MAP_ENTRIES, CSR_DATA_W'(m));
      end
      count = $urandom_range(15, 45);
      repeat (count) send_request(random_request(), 1'b0, '0);
   endtask

   initial begin : stimulus
      int  phase_end;
      bit  full_done;
      full_done = 1'b0;

      rows.push_back(known_result(req_row(MODE_ENCODE, 16'h0041, 8'h00, 8'h00, 1'b1),
                                  16'h0000, ST_ERROR));
      rows.push_back(known_result(req_row(MODE_ENCODE, 16'hFFFF, 8'hFF, 8'hFF, 1'b0),
                                  16'h0000, ST_ERROR));
      rows.push_back(plain_row(req_row(MODE_LOAD_BYTES, 16'h0000, 8'h00, 8'h00, 1'b0)));
      rows.push_back(plain_row(req_row(MODE_LOAD_BYTES, UNUSED_CODE, 8'hFF, 8'hFF, 1'b1)));
      rows.push_back(plain_row(req_row(MODE_LOAD_BYTES, 16'h0041, 8'h41, 8'h00, 1'b0)));
      rows.push_back(plain_row(req_row(MODE_LOAD_BYTES, 16'h20AC, 8'h80, 8'h00, 1'b0)));
      rows.push_back(known_result(req_row(MODE_DECODE, 16'h0000, 8'h00, 8'h00, 1'b1),
                                  16'h0000, ST_OK));
      rows.push_back(known_result(req_row(MODE_DECODE, 16'h00FF, 8'h00, 8'h00, 1'b0),
                                  REPLACEMENT_RESET, ST_REPLACED));
      rows.push_back(plain_row(req_row(MODE_DECODE, 16'h0041, 8'h00, 8'h00, 1'b0)));
      // Only the low byte of a decode request selects the entry.
      rows.push_back(plain_row(req_row(MODE_DECODE, 16'hFF80, 8'h00, 8'h00, 1'b1)));
      rows.push_back(plain_row(req_row(MODE_LOAD_MAP, 16'h0000, 8'h00, 8'h00, 1'b0)));
      rows.push_back(plain_row(req_row(MODE_LOAD_MAP, 16'h0041, 8'h01, 8'h41, 1'b0)));
      rows.push_back(plain_row(req_row(MODE_LOAD_MAP, 16'h20AC, 8'h02, 8'h80, 1'b0)));
      rows.push_back(plain_row(req_row(MODE_LOAD_MAP, 16'hFFFF, 8'h03, 8'hFF, 1'b0)));
      rows.push_back(csr_row(CSR_MAP_ENTRIES, 16'd4));
      rows.push_back(plain_row(req_row(MODE_ENCODE, 16'h20AC, 8'h00, 8'h00, 1'b0)));
      rows.push_back(plain_row(req_row(MODE_ENCODE, 16'hFFFF, 8'h00, 8'h00, 1'b0)));
      rows.push_back(plain_row(req_row(MODE_ENCODE, 16'h0000, 8'h00, 8'h00, 1'b1)));
      // In replace mode an encode miss is still an error.
      rows.push_back(known_result(req_row(MODE_ENCODE, 16'h0042, 8'h00, 8'h00, 1'b0),
                                  16'h0000, ST_ERROR));
      rows.push_back(csr_row(CSR_ERROR_ACTION, CSR_DATA_W'(ACT_STOP)));
      rows.push_back(known_result(req_row(MODE_DECODE, 16'h00FF, 8'h00, 8'h00, 1'b0),
                                  16'h0000, ST_STOP));
      rows.push_back(known_result(req_row(MODE_DECODE, 16'h00FF, 8'h00, 8'h00, 1'b1),
                                  16'h0000, ST_ERROR));
      rows.push_back(known_result(req_row(MODE_ENCODE, 16'h1234, 8'h00, 8'h00, 1'b0),
                                  16'h0000, ST_STOP));
      rows.push_back(csr_row(CSR_ERROR_ACTION, CSR_DATA_W'(ACT_ERROR)));
      rows.push_back(known_result(req_row(MODE_DECODE, 16'h00FF, 8'h00, 8'h00, 1'b0),
                                  16'h0000, ST_ERROR));
      // The undefined action value behaves as always error.
      rows.push_back(csr_row(CSR_ERROR_ACTION, 16'd3));
      rows.push_back(known_result(req_row(MODE_ENCODE, 16'h1234, 8'h00, 8'h00, 1'b0),
                                  16'h0000, ST_ERROR));
      rows.push_back(csr_row(CSR_ERROR_ACTION, CSR_DATA_W'(ACT_REPLACE)));
      rows.push_back(csr_row(CSR_REPLACEMENT, 16'h0000));
      rows.push_back(known_result(req_row(MODE_DECODE, 16'h00FF, 8'h00, 8'h00, 1'b0),
                                  16'h0000, ST_REPLACED));
      rows.push_back(csr_row(CSR_REPLACEMENT, 16'hFFFF));
      rows.push_back(known_result(req_row(MODE_DECODE, 16'h00FF, 8'h00, 8'h00, 1'b1),
                                  16'hFFFF, ST_REPLACED));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            drain_block();
            write_register(rows[i].csr_sel, rows[i].csr_value);
         end else begin
            send_request(rows[i].req, rows[i].is_known, rows[i].known);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 19 : (phase == 1) ? 66 : 0;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            run_episode(phase == 2 && !full_done);
            if (phase == 2) full_done = 1'b1;
         end
      end

      drain_block();
      if (mismatches == 0 && pending_conversions.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/sbcc_pkg.sv
src/single_byte_charset_converter_unit.sv
src/sbcc_checker.sv
verif/tb_single_byte_charset_converter_unit.sv
